@@ design/dxtbd_pkg.sv @@
`timescale 1ns / 1ps

package dxtbd_pkg;

   // block format codes held in the control register
   localparam logic [1:0] FMT_DXT1 = 2'd0;
   localparam logic [1:0] FMT_DXT3 = 2'd1;
   localparam logic [1:0] FMT_DXT5 = 2'd2;

   // channel positions inside a color triple
   localparam int CH_R = 0;
   localparam int CH_G = 1;
   localparam int CH_B = 2;

   // request queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // index of the last texel in a block
   localparam logic [3:0] LAST_TEXEL = 4'd15;

   typedef enum logic [1:0] {
      ALPHA_OPAQUE,
      ALPHA_EXPLICIT,
      ALPHA_INTERP
   } alpha_mode_type;

   // one color as three 8-bit channels
   typedef logic [2:0][7:0] rgb_type;

   // classified block handed from front to back
   typedef struct packed {
      rgb_type         ep0;
      rgb_type         ep1;
      logic            four_color;
      logic [2:0][9:0] cnum2;
      logic [2:0][9:0] cnum3;
      logic [31:0]     cidx;
      alpha_mode_type  amode;
      logic            a_gt;
      logic [5:0][10:0] anum;
      logic [63:0]     aw;
   } desc_type;

   // x / 3 for x below 768, by reciprocal multiply
   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [22:0] p;
      p = 23'(x) * 23'd5462;
      return p[21:14];
   endfunction

   // x / 5 for x up to 1275 (five times the largest alpha)
   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [21:0] p;
      p = 22'(x) * 22'd3277;
      return p[21:14];
   endfunction

   // x / 7 for x below 1792
   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [22:0] p;
      p = 23'(x) * 23'd2341;
      return p[21:14];
   endfunction

endpackage

@@ design/dxtbd_front.sv @@
`timescale 1ns / 1ps

module dxtbd_front (
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [63:0]         req_color_word,
   input  logic [63:0]         req_alpha_word,
   input  logic [1:0]          block_format,
   input  logic                q_full,
   output logic                q_push,
   output dxtbd_pkg::desc_type q_data
);

   logic [15:0] c0;
   logic [15:0] c1;
   logic [10:0] a0;
   logic [10:0] a1;

   assign c0 = req_color_word[15:0];
   assign c1 = req_color_word[31:16];
   assign a0 = {3'b000, req_alpha_word[7:0]};
   assign a1 = {3'b000, req_alpha_word[15:8]};

   // accept a request whenever the queue has room
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   // classify the block and form the palette numerators
   always_comb begin
      logic [9:0] ca;
      logic [9:0] cb;
      q_data = '0;
      q_data.ep0[dxtbd_pkg::CH_R] = {c0[15:11], 3'b000};
      q_data.ep0[dxtbd_pkg::CH_G] = {c0[10:5], 2'b00};
      q_data.ep0[dxtbd_pkg::CH_B] = {c0[4:0], 3'b000};
      q_data.ep1[dxtbd_pkg::CH_R] = {c1[15:11], 3'b000};
      q_data.ep1[dxtbd_pkg::CH_G] = {c1[10:5], 2'b00};
      q_data.ep1[dxtbd_pkg::CH_B] = {c1[4:0], 3'b000};
      q_data.cidx = req_color_word[63:32];
      q_data.aw   = req_alpha_word;

      unique case (block_format)
         dxtbd_pkg::FMT_DXT3: q_data.amode = dxtbd_pkg::ALPHA_EXPLICIT;
         dxtbd_pkg::FMT_DXT5: q_data.amode = dxtbd_pkg::ALPHA_INTERP;
         default:             q_data.amode = dxtbd_pkg::ALPHA_OPAQUE;
      endcase

      // only dxt1 (and the unused code) can fall back to three colors
      q_data.four_color = (c0 > c1) || (block_format == dxtbd_pkg::FMT_DXT3) ||
                          (block_format == dxtbd_pkg::FMT_DXT5);

      // color numerators: thirds in four-color mode, mean in three-color mode
      for (int ch = 0; ch < 3; ch++) begin
         ca = {2'b00, q_data.ep0[ch]};
         cb = {2'b00, q_data.ep1[ch]};
         q_data.cnum2[ch] = q_data.four_color ? ((ca << 1) + cb + 10'd1)
                                              : (ca + cb + 10'd1);
         q_data.cnum3[ch] = ca + (cb << 1) + 10'd1;
      end

      // interpolated alpha numerators for palette entries two to seven
      q_data.a_gt = (a0 > a1);
      for (int j = 0; j < 6; j++) begin
         if (q_data.a_gt) begin
            q_data.anum[j] = 11'(6 - j) * a0 + 11'(j + 1) * a1;
         end else if (j <= 3) begin
            q_data.anum[j] = 11'(4 - j) * a0 + 11'(j + 1) * a1;
         end else begin
            q_data.anum[j] = '0;
         end
      end
   end

endmodule

@@ design/dxtbd_queue.sv @@
`timescale 1ns / 1ps

module dxtbd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dxtbd_pkg::desc_type push_data,
   output logic                full,
   output logic                pop_valid,
   input  logic                pop_ready,
   output dxtbd_pkg::desc_type pop_data
);

   dxtbd_pkg::desc_type             mem_ff [dxtbd_pkg::QDEPTH];
   logic [dxtbd_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [dxtbd_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [dxtbd_pkg::QCNT_W-1:0]    cnt_ff, cnt_in;
   logic                            pop;

   assign full      = (cnt_ff == dxtbd_pkg::QCNT_W'(dxtbd_pkg::QDEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == dxtbd_pkg::QPTR_W'(dxtbd_pkg::QDEPTH - 1)) ? '0
                                                                          : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == dxtbd_pkg::QPTR_W'(dxtbd_pkg::QDEPTH - 1)) ? '0
                                                                          : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/dxtbd_back.sv @@
`timescale 1ns / 1ps

module dxtbd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  dxtbd_pkg::desc_type pop_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_red,
   output logic [7:0]          rsp_green,
   output logic [7:0]          rsp_blue,
   output logic [7:0]          rsp_alpha_out,
   output logic [1:0]          rsp_texel_x,
   output logic [1:0]          rsp_texel_y,
   output logic                rsp_last_texel
);

   // palette stage
   logic                      p_valid_ff, p_valid_in;
   logic [3:0][2:0][7:0]      p_cpal_ff, p_cpal_in;
   logic [7:0][7:0]           p_apal_ff, p_apal_in;
   dxtbd_pkg::alpha_mode_type p_amode_ff;
   logic [63:0]               p_aw_ff;
   logic [31:0]               p_cidx_ff;

   // texel stage
   logic                      s_valid_ff, s_valid_in;
   logic [3:0]                s_cnt_ff, s_cnt_in;
   logic [3:0][2:0][7:0]      s_cpal_ff;
   logic [7:0][7:0]           s_apal_ff;
   dxtbd_pkg::alpha_mode_type s_amode_ff;
   logic [63:0]               s_aw_ff;
   logic [31:0]               s_cidx_ff;

   // output register
   logic                      o_valid_ff, o_valid_in;
   logic [7:0]                o_red_ff, o_green_ff, o_blue_ff, o_alpha_ff;
   logic [1:0]                o_x_ff, o_y_ff;
   logic                      o_last_ff;
   logic [7:0]                t_alpha;
   logic [1:0]                t_cidx;
   logic [2:0]                t_aidx;
   logic [3:0]                t_nib;

   logic out_load, s_emit, s_done, s_load, p_load;

   // stage handoff
   assign out_load  = !o_valid_ff || rsp_ready;
   assign s_emit    = s_valid_ff && out_load;
   assign s_done    = s_emit && (s_cnt_ff == dxtbd_pkg::LAST_TEXEL);
   assign s_load    = p_valid_ff && (!s_valid_ff || s_done);
   assign pop_ready = !p_valid_ff || s_load;
   assign p_load    = pop_valid && pop_ready;

   always_comb begin
      p_valid_in = p_valid_ff;
      if (p_load) begin
         p_valid_in = 1'b1;
      end else if (s_load) begin
         p_valid_in = 1'b0;
      end
      s_valid_in = s_valid_ff;
      s_cnt_in   = s_cnt_ff;
      if (s_load) begin
         s_valid_in = 1'b1;
         s_cnt_in   = '0;
      end else if (s_done) begin
         s_valid_in = 1'b0;
      end else if (s_emit) begin
         s_cnt_in = s_cnt_ff + 1'b1;
      end
      o_valid_in = out_load ? s_valid_ff : o_valid_ff;
   end

   // finish the color and alpha palettes from the numerators
   always_comb begin
      p_cpal_in[0] = pop_data.ep0;
      p_cpal_in[1] = pop_data.ep1;
      for (int ch = 0; ch < 3; ch++) begin
         if (pop_data.four_color) begin
            p_cpal_in[2][ch] = dxtbd_pkg::div3(pop_data.cnum2[ch]);
            p_cpal_in[3][ch] = dxtbd_pkg::div3(pop_data.cnum3[ch]);
         end else begin
            p_cpal_in[2][ch] = pop_data.cnum2[ch][8:1];
            p_cpal_in[3][ch] = '0;
         end
      end
      p_apal_in[0] = pop_data.aw[7:0];
      p_apal_in[1] = pop_data.aw[15:8];
      for (int j = 0; j < 6; j++) begin
         if (pop_data.a_gt) begin
            p_apal_in[j+2] = dxtbd_pkg::div7(pop_data.anum[j]);
         end else if (j <= 3) begin
            p_apal_in[j+2] = dxtbd_pkg::div5(pop_data.anum[j]);
         end else if (j == 4) begin
            p_apal_in[j+2] = 8'd0;
         end else begin
            p_apal_in[j+2] = 8'd255;
         end
      end
   end

   // pick the current texel
   assign t_cidx = s_cidx_ff[{s_cnt_ff, 1'b0} +: 2];
   assign t_aidx = s_aw_ff[16 + 3 * s_cnt_ff +: 3];
   assign t_nib  = s_aw_ff[{s_cnt_ff, 2'b00} +: 4];

   always_comb begin
      unique case (s_amode_ff)
         dxtbd_pkg::ALPHA_EXPLICIT: t_alpha = {t_nib, t_nib};
         dxtbd_pkg::ALPHA_INTERP:   t_alpha = s_apal_ff[t_aidx];
         default:                   t_alpha = 8'd255;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         s_cnt_ff   <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
         s_valid_ff <= s_valid_in;
         s_cnt_ff   <= s_cnt_in;
         o_valid_ff <= o_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (p_load) begin
         p_cpal_ff  <= p_cpal_in;
         p_apal_ff  <= p_apal_in;
         p_amode_ff <= pop_data.amode;
         p_aw_ff    <= pop_data.aw;
         p_cidx_ff  <= pop_data.cidx;
      end
      if (s_load) begin
         s_cpal_ff  <= p_cpal_ff;
         s_apal_ff  <= p_apal_ff;
         s_amode_ff <= p_amode_ff;
         s_aw_ff    <= p_aw_ff;
         s_cidx_ff  <= p_cidx_ff;
      end
      if (s_emit) begin
         o_red_ff   <= s_cpal_ff[t_cidx][dxtbd_pkg::CH_R];
         o_green_ff <= s_cpal_ff[t_cidx][dxtbd_pkg::CH_G];
         o_blue_ff  <= s_cpal_ff[t_cidx][dxtbd_pkg::CH_B];
         o_alpha_ff <= t_alpha;
         o_x_ff     <= s_cnt_ff[1:0];
         o_y_ff     <= s_cnt_ff[3:2];
         o_last_ff  <= (s_cnt_ff == dxtbd_pkg::LAST_TEXEL);
      end
   end

   assign rsp_valid      = o_valid_ff;
   assign rsp_red        = o_red_ff;
   assign rsp_green      = o_green_ff;
   assign rsp_blue       = o_blue_ff;
   assign rsp_alpha_out  = o_alpha_ff;
   assign rsp_texel_x    = o_x_ff;
   assign rsp_texel_y    = o_y_ff;
   assign rsp_last_texel = o_last_ff;

endmodule

@@ design/dxt_block_decoder_top.sv @@
`timescale 1ns / 1ps

// S3TC block decoder: each request carries one compressed 4x4 block (color word
// and alpha word) and yields sixteen texel responses in row-major order, one per
// cycle while rsp_ready is high, serialized through the single texel output
// register. A new request is taken while the previous block is still streaming
// out: a two-entry queue sits between the classifying front and the palette/texel
// back, and the back keeps one block in its palette stage while another drains.
// A request passes the queue, palette, texel and output registers before its
// first texel appears. csr_wr_data selects the format (0 DXT1, 1 DXT3, 2 DXT5,
// 3 treated as DXT1); the user must write it only while the block is idle; the
// block does not enforce this. No clearing pass follows reset.
module dxt_block_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_color_word,
   input  logic [63:0] req_alpha_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha_out,
   output logic [1:0]  rsp_texel_x,
   output logic [1:0]  rsp_texel_y,
   output logic        rsp_last_texel,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);

   logic [1:0]          fmt_ff;
   logic                q_full, q_push, q_pop_valid, q_pop_ready;
   dxtbd_pkg::desc_type q_push_data, q_pop_data;

   // format register
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= dxtbd_pkg::FMT_DXT1;
      end else if (csr_wr_en) begin
         fmt_ff <= csr_wr_data;
      end
   end

   dxtbd_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_color_word (req_color_word),
      .req_alpha_word (req_alpha_word),
      .block_format   (fmt_ff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (q_push_data)
   );

   dxtbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop_valid (q_pop_valid),
      .pop_ready (q_pop_ready),
      .pop_data  (q_pop_data)
   );

   dxtbd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (q_pop_valid),
      .pop_ready      (q_pop_ready),
      .pop_data       (q_pop_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_alpha_out  (rsp_alpha_out),
      .rsp_texel_x    (rsp_texel_x),
      .rsp_texel_y    (rsp_texel_y),
      .rsp_last_texel (rsp_last_texel)
   );

endmodule

@@ design/dxtbd_checker.sv @@
`timescale 1ns / 1ps

module dxtbd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_red,
   input logic [7:0]  rsp_green,
   input logic [7:0]  rsp_blue,
   input logic [7:0]  rsp_alpha_out,
   input logic [1:0]  rsp_texel_x,
   input logic [1:0]  rsp_texel_y,
   input logic        rsp_last_texel,
   input logic        csr_wr_en,
   input logic [1:0]  csr_wr_data
);

   logic [3:0] cnt_ff;
   logic [1:0] fmt_ff;

   // shadow of the texel position and the format register
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         fmt_ff <= dxtbd_pkg::FMT_DXT1;
      end else begin
         if (rsp_valid && rsp_ready) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (csr_wr_en) begin
            fmt_ff <= csr_wr_data;
         end
      end
   end

   // a stalled response holds its texel
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green) &&
         $stable(rsp_blue) && $stable(rsp_alpha_out) && $stable(rsp_texel_x) &&
         $stable(rsp_texel_y) && $stable(rsp_last_texel))
      else $error("stalled response changed");

   // texels leave in row-major order with no gaps
   a_rsp_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {rsp_texel_y, rsp_texel_x} == cnt_ff)
      else $error("texel out of order");

   // last flag marks exactly the sixteenth texel
   a_rsp_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_texel == (cnt_ff == dxtbd_pkg::LAST_TEXEL))
      else $error("last texel flag wrong");

   // dxt1 texels (and the unused code) are opaque
   a_opaque: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && fmt_ff != dxtbd_pkg::FMT_DXT3 && fmt_ff != dxtbd_pkg::FMT_DXT5 |->
         rsp_alpha_out == 8'd255)
      else $error("dxt1 texel not opaque");

endmodule

bind dxt_block_decoder_top dxtbd_checker u_dxtbd_checker (.*);
